// ===== rtl/core/bpc_pkg.sv =====
package bpc_pkg;

    // configuration register indexes
    typedef enum logic [3:0] {
        REG_AC1    = 4'd0,
        REG_AC2    = 4'd1,
        REG_AC3    = 4'd2,
        REG_AC4    = 4'd3,
        REG_AC5    = 4'd4,
        REG_AC6    = 4'd5,
        REG_B1_B2  = 4'd6,
        REG_MC_MD  = 4'd7
    } cfg_index_t;

    localparam int CFG_INDEX_W  = 4;
    localparam int CFG_DATA_W   = 32;
    localparam int IN_DATA_W    = 40;
    localparam int OUT_DATA_W   = 40;
    localparam int TEMP_W       = 16;
    localparam int PRES_W       = 18;
    localparam int RAW_T_W      = 16;
    localparam int RAW_P_W      = 18;

    localparam int OVERSAMPLING_DEFAULT = 2;

    // formula constants
    localparam int B6_OFFSET = 4000;
    localparam int B4_BIAS   = 32768;
    localparam int B7_SCALE  = 50000;
    localparam int P_QUAD    = 3038;
    localparam int P_LIN     = -7357;
    localparam int P_BIAS    = 3791;

endpackage

// ===== rtl/core/bpc_div.sv =====
module bpc_div #(
    parameter int DIVIDEND_W = 32,
    parameter int DIVISOR_W  = 17,
    parameter int SIDE_W     = 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  in_valid,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    input  logic [SIDE_W-1:0]     side_in,
    output logic                  out_valid,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic [SIDE_W-1:0]     side_out
);

    // one quotient bit per stage, restoring
    logic                  v_reg    [0:DIVIDEND_W];
    logic [DIVISOR_W-1:0]  rem_reg  [0:DIVIDEND_W];
    logic [DIVIDEND_W-1:0] num_reg  [0:DIVIDEND_W];
    logic [DIVISOR_W-1:0]  dsr_reg  [0:DIVIDEND_W];
    logic [SIDE_W-1:0]     sd_reg   [0:DIVIDEND_W];

    logic [DIVISOR_W:0]    trial    [0:DIVIDEND_W-1];
    logic                  ge       [0:DIVIDEND_W-1];
    logic [DIVISOR_W:0]    diff     [0:DIVIDEND_W-1];
    logic [DIVISOR_W-1:0]  rem_next [0:DIVIDEND_W-1];
    logic [DIVIDEND_W-1:0] num_next [0:DIVIDEND_W-1];

    always_comb
    begin
        for (int k = 0; k < DIVIDEND_W; k++)
        begin
            trial[k]    = {rem_reg[k], num_reg[k][DIVIDEND_W-1]};
            ge[k]       = trial[k] >= {1'b0, dsr_reg[k]};
            diff[k]     = trial[k] - {1'b0, dsr_reg[k]};
            rem_next[k] = ge[k] ? diff[k][DIVISOR_W-1:0] : trial[k][DIVISOR_W-1:0];
            num_next[k] = {num_reg[k][DIVIDEND_W-2:0], ge[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DIVIDEND_W; k++)
                v_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
            for (int k = 0; k < DIVIDEND_W; k++)
                v_reg[k+1] <= v_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= '0;
            num_reg[0] <= dividend;
            dsr_reg[0] <= divisor;
            sd_reg[0]  <= side_in;
            for (int k = 0; k < DIVIDEND_W; k++)
            begin
                rem_reg[k+1] <= rem_next[k];
                num_reg[k+1] <= num_next[k];
                dsr_reg[k+1] <= dsr_reg[k];
                sd_reg[k+1]  <= sd_reg[k];
            end
        end
    end

    assign out_valid = v_reg[DIVIDEND_W];
    assign quotient  = num_reg[DIVIDEND_W];
    assign side_out  = sd_reg[DIVIDEND_W];

endmodule

// ===== rtl/core/barometric_pressure_compensation.sv =====
// throughput: one request per cycle while the output is not stalled; the two
// bit-serial divider pipelines (27 and 32 stages, one quotient bit each) set
// the depth, not the rate
// the whole pipeline advances together and holds while the output stalls
// reset (rst_n, async, active low): all valid bits and calibration words clear
module barometric_pressure_compensation #(
    parameter int OVERSAMPLING = bpc_pkg::OVERSAMPLING_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // calibration write port
    input  logic                             cfg_wen,
    input  logic [bpc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bpc_pkg::CFG_DATA_W-1:0]   cfg_data,
    // raw readings
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [bpc_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // raw_temperature, raw_pressure
    // compensated results
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [bpc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // temperature, pressure
    output logic                             m_axis_tuser   // div_error
);

    // only the low two bits of the oversampling setting count
    localparam logic [1:0] OSS     = OVERSAMPLING[1:0];
    localparam int         B7_MULT = bpc_pkg::B7_SCALE >> OSS;

    // ---------------------------------------------------------------
    // calibration words
    // ---------------------------------------------------------------
    logic [15:0] ac1_reg, ac2_reg, ac3_reg, ac4_reg, ac5_reg, ac6_reg;
    logic [31:0] b1b2_reg, mcmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ac1_reg  <= '0;
            ac2_reg  <= '0;
            ac3_reg  <= '0;
            ac4_reg  <= '0;
            ac5_reg  <= '0;
            ac6_reg  <= '0;
            b1b2_reg <= '0;
            mcmd_reg <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (bpc_pkg::cfg_index_t'(cfg_index))
                bpc_pkg::REG_AC1:   ac1_reg  <= cfg_data[15:0];
                bpc_pkg::REG_AC2:   ac2_reg  <= cfg_data[15:0];
                bpc_pkg::REG_AC3:   ac3_reg  <= cfg_data[15:0];
                bpc_pkg::REG_AC4:   ac4_reg  <= cfg_data[15:0];
                bpc_pkg::REG_AC5:   ac5_reg  <= cfg_data[15:0];
                bpc_pkg::REG_AC6:   ac6_reg  <= cfg_data[15:0];
                bpc_pkg::REG_B1_B2: b1b2_reg <= cfg_data;
                bpc_pkg::REG_MC_MD: mcmd_reg <= cfg_data;
                default:            ; // unknown index, ignored
            endcase
        end
    end

    logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
    assign ac1 = $signed(ac1_reg);
    assign ac2 = $signed(ac2_reg);
    assign ac3 = $signed(ac3_reg);
    assign b1  = $signed(b1b2_reg[31:16]);
    assign b2  = $signed(b1b2_reg[15:0]);
    assign mc  = $signed(mcmd_reg[31:16]);
    assign md  = $signed(mcmd_reg[15:0]);

    // ---------------------------------------------------------------
    // global advance: everything moves unless the output holds a
    // result that is not being taken
    // ---------------------------------------------------------------
    logic out_valid_reg;
    logic adv;
    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    // ---------------------------------------------------------------
    // stage 1: capture the readings
    // ---------------------------------------------------------------
    logic        v1_reg;
    logic [15:0] ut1_reg;
    logic [17:0] up1_reg;

    // ---------------------------------------------------------------
    // stage 2: x1 = (ut - ac6) * ac5 >> 15
    // ---------------------------------------------------------------
    logic               v2_reg;
    logic signed [17:0] x1t2_reg;
    logic [17:0]        up2_reg;

    logic signed [16:0] t_diff;
    logic signed [33:0] t_prod;
    assign t_diff = $signed({1'b0, ut1_reg}) - $signed({1'b0, ac6_reg});
    assign t_prod = t_diff * $signed({1'b0, ac5_reg});

    // ---------------------------------------------------------------
    // temperature divider: mc * 2048 / (x1 + md), sign-magnitude
    // ---------------------------------------------------------------
    logic signed [18:0] t_den;
    logic [18:0]        t_den_mag;
    logic [15:0]        mc_mag;
    logic [26:0]        t_num_mag;
    logic               t_neg;
    logic               t_zero;

    assign t_den     = 19'(x1t2_reg) + 19'(md);
    assign t_den_mag = t_den[18] ? 19'(-t_den) : 19'(t_den);
    assign mc_mag    = mc[15] ? (~mcmd_reg[31:16] + 16'd1) : mcmd_reg[31:16];
    assign t_num_mag = {mc_mag, 11'd0};
    assign t_neg     = mc[15] ^ t_den[18];
    assign t_zero    = (t_den == '0);

    // side: up(18), x1(18), neg, zero
    localparam int TSIDE_W = 38;
    logic               tdiv_valid;
    logic [26:0]        tdiv_q;
    logic [TSIDE_W-1:0] tdiv_side;

    bpc_div #(
        .DIVIDEND_W (27),
        .DIVISOR_W  (19),
        .SIDE_W     (TSIDE_W)
    ) u_tdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v2_reg),
        .dividend  (t_num_mag),
        .divisor   (t_den_mag),
        .side_in   ({up2_reg, x1t2_reg, t_neg, t_zero}),
        .out_valid (tdiv_valid),
        .quotient  (tdiv_q),
        .side_out  (tdiv_side)
    );

    logic [17:0]        td_up;
    logic signed [17:0] td_x1;
    logic               td_neg, td_zero;
    assign td_up   = tdiv_side[37:20];
    assign td_x1   = $signed(tdiv_side[19:2]);
    assign td_neg  = tdiv_side[1];
    assign td_zero = tdiv_side[0];

    // ---------------------------------------------------------------
    // stage 4: b5 = x1 + x2
    // ---------------------------------------------------------------
    logic               v4_reg;
    logic signed [28:0] b5_4_reg;
    logic [17:0]        up4_reg;
    logic               z4_reg;

    logic signed [27:0] t_x2;
    assign t_x2 = td_neg ? -$signed({1'b0, tdiv_q}) : $signed({1'b0, tdiv_q});

    // ---------------------------------------------------------------
    // stage 5: temperature rounding and clamp, b6 = b5 - 4000
    // ---------------------------------------------------------------
    logic               v5_reg;
    logic signed [15:0] t5_reg;
    logic signed [29:0] b6_5_reg;
    logic [17:0]        up5_reg;
    logic               z5_reg;

    logic signed [29:0] b5_rnd;
    logic signed [25:0] t_full;
    logic signed [15:0] t_clamp;
    assign b5_rnd = 30'(b5_4_reg) + 30'sd8;
    assign t_full = b5_rnd[29:4];

    always_comb
    begin
        priority if (t_full > 26'sd32767)
            t_clamp = 16'sh7fff;
        else if (t_full < -26'sd32768)
            t_clamp = 16'sh8000;
        else
            t_clamp = t_full[15:0];
    end

    // ---------------------------------------------------------------
    // stage 6: b6 squared, ac2 * b6, ac3 * b6
    // ---------------------------------------------------------------
    logic               v6_reg;
    logic [45:0]        sq6_reg;
    logic signed [34:0] a2_6_reg;
    logic signed [32:0] a3_6_reg;
    logic signed [15:0] t6_reg;
    logic [17:0]        up6_reg;
    logic               z6_reg;

    logic signed [59:0] sq_prod;
    logic signed [45:0] a2_prod, a3_prod;
    assign sq_prod = b6_5_reg * b6_5_reg;
    assign a2_prod = 46'(ac2) * 46'(b6_5_reg);
    assign a3_prod = 46'(ac3) * 46'(b6_5_reg);

    // ---------------------------------------------------------------
    // stage 7: b2 * sq and b1 * sq as two partial products each
    // ---------------------------------------------------------------
    logic               v7_reg;
    logic signed [38:0] pb2h_reg, pb1h_reg;
    logic signed [40:0] pb2l_reg, pb1l_reg;
    logic signed [34:0] a2_7_reg;
    logic signed [32:0] a3_7_reg;
    logic signed [15:0] t7_reg;
    logic [17:0]        up7_reg;
    logic               z7_reg;

    logic signed [22:0] sq_hi;
    logic signed [24:0] sq_lo;
    assign sq_hi = $signed({1'b0, sq6_reg[45:24]});
    assign sq_lo = $signed({1'b0, sq6_reg[23:0]});

    // ---------------------------------------------------------------
    // stage 8: combine partial products
    // ---------------------------------------------------------------
    logic               v8_reg;
    logic signed [63:0] s2_8_reg, s1_8_reg;
    logic signed [34:0] a2_8_reg;
    logic signed [32:0] a3_8_reg;
    logic signed [15:0] t8_reg;
    logic [17:0]        up8_reg;
    logic               z8_reg;

    // ---------------------------------------------------------------
    // stage 9: b3 and the b4 offset term, kept modulo 2^32
    // ---------------------------------------------------------------
    logic               v9_reg;
    logic [31:0]        b3_9_reg, x3b_9_reg;
    logic signed [15:0] t9_reg;
    logic [17:0]        up9_reg;
    logic               z9_reg;

    logic signed [63:0] p_x3, p_b3pre, p_b3, p_x3b_sum, p_x3b;
    assign p_x3      = (s2_8_reg >>> 11) + 64'(a2_8_reg);
    assign p_b3pre   = (((64'(ac1) <<< 2) + p_x3) <<< OSS) + 64'sd2;
    assign p_b3      = p_b3pre >>> 2;
    assign p_x3b_sum = 64'(a3_8_reg) + (s1_8_reg >>> 16) + 64'sd2;
    assign p_x3b     = p_x3b_sum >>> 2;

    // ---------------------------------------------------------------
    // stage 10: b4 and up - b3
    // ---------------------------------------------------------------
    logic               v10_reg;
    logic [31:0]        diff10_reg;
    logic [16:0]        b4_10_reg;
    logic signed [15:0] t10_reg;
    logic               z10_reg;

    logic [31:0] b4_prod;
    assign b4_prod = {16'd0, ac4_reg} * (x3b_9_reg + 32'(bpc_pkg::B4_BIAS));

    // ---------------------------------------------------------------
    // stage 11: b7 and the divisor check
    // ---------------------------------------------------------------
    logic               v11_reg;
    logic [31:0]        b7_11_reg;
    logic [16:0]        b4_11_reg;
    logic signed [15:0] t11_reg;
    logic               err11_reg;

    // pressure divider: doubling goes before or after by the top bit of b7
    logic [31:0] p_num;
    logic        p_hi;
    assign p_hi  = b7_11_reg[31];
    assign p_num = p_hi ? b7_11_reg : {b7_11_reg[30:0], 1'b0};

    // side: t(16), err, hi
    localparam int PSIDE_W = 18;
    logic               pdiv_valid;
    logic [31:0]        pdiv_q;
    logic [PSIDE_W-1:0] pdiv_side;

    bpc_div #(
        .DIVIDEND_W (32),
        .DIVISOR_W  (17),
        .SIDE_W     (PSIDE_W)
    ) u_pdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v11_reg),
        .dividend  (p_num),
        .divisor   (b4_11_reg),
        .side_in   ({t11_reg, err11_reg, p_hi}),
        .out_valid (pdiv_valid),
        .quotient  (pdiv_q),
        .side_out  (pdiv_side)
    );

    // ---------------------------------------------------------------
    // stage 12: p, (p >> 8)^2, -7357 * p
    // ---------------------------------------------------------------
    logic               v12_reg;
    logic signed [31:0] ps12_reg;
    logic [46:0]        m12_reg;
    logic signed [29:0] x2_12_reg;
    logic signed [15:0] t12_reg;
    logic               err12_reg;

    logic [31:0]        q_full;
    logic signed [31:0] ps_val;
    logic signed [23:0] p8;
    logic signed [47:0] p8_sq;
    logic signed [45:0] lin_prod;
    assign q_full   = pdiv_side[0] ? {pdiv_q[30:0], 1'b0} : pdiv_q;
    assign ps_val   = $signed(q_full);
    assign p8       = ps_val[31:8];
    assign p8_sq    = p8 * p8;
    assign lin_prod = 46'(ps_val) * 46'(bpc_pkg::P_LIN);

    // ---------------------------------------------------------------
    // stage 13: 3038 * (p >> 8)^2 as two partial products
    // ---------------------------------------------------------------
    logic               v13_reg;
    logic [34:0]        ph13_reg;
    logic [35:0]        pl13_reg;
    logic signed [31:0] ps13_reg;
    logic signed [29:0] x2_13_reg;
    logic signed [15:0] t13_reg;
    logic               err13_reg;

    // ---------------------------------------------------------------
    // stage 14: correction term
    // ---------------------------------------------------------------
    logic               v14_reg;
    logic signed [40:0] corr14_reg;
    logic signed [31:0] ps14_reg;
    logic signed [15:0] t14_reg;
    logic               err14_reg;

    logic [58:0]        quad_full;
    logic [42:0]        quad;
    logic signed [44:0] corr_sum;
    assign quad_full = (59'(ph13_reg) << 24) + 59'(pl13_reg);
    assign quad      = quad_full[58:16];
    assign corr_sum  = $signed({2'b00, quad}) + 45'(x2_13_reg) + 45'(bpc_pkg::P_BIAS);

    // ---------------------------------------------------------------
    // output register: final sum, clamp, error zeroing
    // ---------------------------------------------------------------
    logic signed [44:0] ps_fin;
    logic [17:0]        p_clamp;
    logic [15:0]        t_out_next;
    logic [17:0]        p_out_next;
    assign ps_fin = 45'(ps14_reg) + 45'(corr14_reg);

    always_comb
    begin
        priority if (ps_fin < 45'sd0)
            p_clamp = '0;
        else if (ps_fin > 45'sd262143)
            p_clamp = '1;
        else
            p_clamp = ps_fin[17:0];
    end

    assign t_out_next = err14_reg ? '0 : t14_reg;
    assign p_out_next = err14_reg ? '0 : p_clamp;

    logic [15:0] t_out_reg;
    logic [17:0] p_out_reg;
    logic        err_out_reg;

    // ---------------------------------------------------------------
    // valid chain
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            v8_reg        <= 1'b0;
            v9_reg        <= 1'b0;
            v10_reg       <= 1'b0;
            v11_reg       <= 1'b0;
            v12_reg       <= 1'b0;
            v13_reg       <= 1'b0;
            v14_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= s_axis_tvalid;
            v2_reg        <= v1_reg;
            v4_reg        <= tdiv_valid;
            v5_reg        <= v4_reg;
            v6_reg        <= v5_reg;
            v7_reg        <= v6_reg;
            v8_reg        <= v7_reg;
            v9_reg        <= v8_reg;
            v10_reg       <= v9_reg;
            v11_reg       <= v10_reg;
            v12_reg       <= pdiv_valid;
            v13_reg       <= v12_reg;
            v14_reg       <= v13_reg;
            out_valid_reg <= v14_reg;
        end
    end

    // ---------------------------------------------------------------
    // data path registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // stage 1
            ut1_reg    <= s_axis_tdata[15:0];
            up1_reg    <= s_axis_tdata[33:16];
            // stage 2
            x1t2_reg   <= t_prod[32:15];
            up2_reg    <= up1_reg;
            // stage 4
            b5_4_reg   <= 29'(td_x1) + 29'(t_x2);
            up4_reg    <= td_up;
            z4_reg     <= td_zero;
            // stage 5
            t5_reg     <= t_clamp;
            b6_5_reg   <= 30'(b5_4_reg) - 30'(bpc_pkg::B6_OFFSET);
            up5_reg    <= up4_reg;
            z5_reg     <= z4_reg;
            // stage 6
            sq6_reg    <= sq_prod[57:12];
            a2_6_reg   <= a2_prod[45:11];
            a3_6_reg   <= a3_prod[45:13];
            t6_reg     <= t5_reg;
            up6_reg    <= up5_reg;
            z6_reg     <= z5_reg;
            // stage 7
            pb2h_reg   <= 39'(b2) * 39'(sq_hi);
            pb2l_reg   <= 41'(b2) * 41'(sq_lo);
            pb1h_reg   <= 39'(b1) * 39'(sq_hi);
            pb1l_reg   <= 41'(b1) * 41'(sq_lo);
            a2_7_reg   <= a2_6_reg;
            a3_7_reg   <= a3_6_reg;
            t7_reg     <= t6_reg;
            up7_reg    <= up6_reg;
            z7_reg     <= z6_reg;
            // stage 8
            s2_8_reg   <= (64'(pb2h_reg) <<< 24) + 64'(pb2l_reg);
            s1_8_reg   <= (64'(pb1h_reg) <<< 24) + 64'(pb1l_reg);
            a2_8_reg   <= a2_7_reg;
            a3_8_reg   <= a3_7_reg;
            t8_reg     <= t7_reg;
            up8_reg    <= up7_reg;
            z8_reg     <= z7_reg;
            // stage 9
            b3_9_reg   <= p_b3[31:0];
            x3b_9_reg  <= p_x3b[31:0];
            t9_reg     <= t8_reg;
            up9_reg    <= up8_reg;
            z9_reg     <= z8_reg;
            // stage 10
            diff10_reg <= {14'd0, up9_reg} - b3_9_reg;
            b4_10_reg  <= b4_prod[31:15];
            t10_reg    <= t9_reg;
            z10_reg    <= z9_reg;
            // stage 11
            b7_11_reg  <= diff10_reg * 32'(B7_MULT);
            b4_11_reg  <= b4_10_reg;
            t11_reg    <= t10_reg;
            err11_reg  <= z10_reg || (b4_10_reg == '0);
            // stage 12
            ps12_reg   <= ps_val;
            m12_reg    <= p8_sq[46:0];
            x2_12_reg  <= lin_prod[45:16];
            t12_reg    <= $signed(pdiv_side[17:2]);
            err12_reg  <= pdiv_side[1];
            // stage 13
            ph13_reg   <= 35'(m12_reg[46:24]) * 35'(bpc_pkg::P_QUAD);
            pl13_reg   <= 36'(m12_reg[23:0]) * 36'(bpc_pkg::P_QUAD);
            ps13_reg   <= ps12_reg;
            x2_13_reg  <= x2_12_reg;
            t13_reg    <= t12_reg;
            err13_reg  <= err12_reg;
            // stage 14
            corr14_reg <= corr_sum[44:4];
            ps14_reg   <= ps13_reg;
            t14_reg    <= t13_reg;
            err14_reg  <= err13_reg;
            // output
            t_out_reg   <= t_out_next;
            p_out_reg   <= p_out_next;
            err_out_reg <= err14_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, p_out_reg, t_out_reg};
    assign m_axis_tuser  = err_out_reg;

endmodule

// ===== rtl/core/bpc_check.sv =====
module bpc_check (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [bpc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input logic                            m_axis_tuser
);

    // the input side only waits while a finished result is held
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");

    // a divisor error comes with zero results
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("error result carries nonzero data");

    // pad bits above the pressure stay clear
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[bpc_pkg::OUT_DATA_W-1:34] == '0))
        else $error("output pad bits set");

    // a stalled result stays
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("stalled result dropped");

    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            ($stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind barometric_pressure_compensation bpc_check u_bpc_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
